@@ hw/rtl/bfp_pkg.sv @@
// shared types and constants of the bit field packer
package bfp_pkg;

  // bit offset width, wide enough for the largest supported buffer
  localparam int OFF_W = 20;

  // queue depths between the parts
  localparam int CMD_DEPTH = 2;
  localparam int RES_DEPTH = 2;

  // request codes
  localparam logic [1:0] REQ_APPEND = 2'd0;
  localparam logic [1:0] REQ_CLEAR  = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_ILLEGAL    = 2'd1;
  localparam logic [1:0] ST_OVERFLOW   = 2'd2;
  localparam logic [1:0] ST_READ_RANGE = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_LENGTH_ENABLE     = 2'd0;
  localparam logic [1:0] CFG_LENGTH_FIELD_BYTE = 2'd1;

  // work the back end has to do for one transaction
  typedef enum logic [1:0] {
    CMD_PASS,
    CMD_APPEND,
    CMD_CLEAR,
    CMD_READ
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [63:0]      field;
    logic [6:0]       count;
    logic [OFF_W-1:0] off_before;
    logic [OFF_W-1:0] off_after;
    logic [11:0]      read_index;
    logic [12:0]      byte_length;
    logic [1:0]       status;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [12:0] byte_length;
    logic [1:0]  status;
  } res_t;

  typedef enum logic [2:0] {
    B_DISPATCH,
    B_WR1,
    B_PATCH,
    B_PATCH2,
    B_READ
  } back_state_t;

endpackage

@@ hw/rtl/bfp_fifo.sv @@
// small first-in first-out queue of register entries
module bfp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wp;
  logic [AW-1:0]    rp;
  logic [CW-1:0]    cnt;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt == CW'(DEPTH));
  assign empty   = (cnt == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rp];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_push) begin
        wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (do_pop) begin
        rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp] <= wdata;
    end
  end

endmodule

@@ hw/rtl/bfp_front.sv @@
// front end: accepts requests, tracks the bit offset and classifies each transaction
module bfp_front #(
  parameter int BUF_BYTES = 4096
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic          cmd_full,
  input  logic [1:0]    req_type,
  input  logic [63:0]   value,
  input  logic [6:0]    bit_count,
  input  logic [5:0]    start_bit,
  input  logic [11:0]   read_index,
  output logic          cmd_push,
  output bfp_pkg::cmd_t cmd
);

  localparam int OW = bfp_pkg::OFF_W;
  localparam logic [OW:0] LIMIT = (OW + 1)'(BUF_BYTES * 8);

  logic [OW-1:0] bit_offset;
  logic [OW-1:0] bit_offset_next;
  logic [7:0]    range_end;
  logic          illegal;
  logic [OW:0]   off_plus;
  logic          overflow;
  logic [OW:0]   used_now;
  logic [OW:0]   used_after;
  logic [63:0]   mask;

  assign cmd_push = push && !cmd_full;

  // classify the request and work out the offset it leaves behind
  always_comb begin
    range_end = {2'b0, start_bit} + {1'b0, bit_count};
    illegal   = (bit_count == '0) || (range_end > 8'd64);
    off_plus  = {1'b0, bit_offset} + (OW + 1)'(bit_count);
    overflow  = off_plus > LIMIT;
    used_now  = ({1'b0, bit_offset} + (OW + 1)'(7)) >> 3;
    mask      = ~(64'hFFFF_FFFF_FFFF_FFFF << bit_count);

    cmd.kind        = bfp_pkg::CMD_PASS;
    cmd.field       = (value >> start_bit) & mask;
    cmd.count       = bit_count;
    cmd.off_before  = bit_offset;
    cmd.off_after   = bit_offset;
    cmd.read_index  = read_index;
    cmd.status      = bfp_pkg::ST_OK;
    bit_offset_next = bit_offset;

    unique case (req_type)
      bfp_pkg::REQ_APPEND: begin
        if (illegal) begin
          cmd.status = bfp_pkg::ST_ILLEGAL;
        end else if (overflow) begin
          cmd.status = bfp_pkg::ST_OVERFLOW;
        end else begin
          cmd.kind        = bfp_pkg::CMD_APPEND;
          cmd.off_after   = off_plus[OW-1:0];
          bit_offset_next = off_plus[OW-1:0];
        end
      end
      bfp_pkg::REQ_CLEAR: begin
        cmd.kind        = bfp_pkg::CMD_CLEAR;
        cmd.off_after   = '0;
        bit_offset_next = '0;
      end
      bfp_pkg::REQ_READ: begin
        if ((OW + 1)'(read_index) < used_now) begin
          cmd.kind = bfp_pkg::CMD_READ;
        end else begin
          cmd.status = bfp_pkg::ST_READ_RANGE;
        end
      end
      default: begin
      end
    endcase

    used_after      = ({1'b0, cmd.off_after} + (OW + 1)'(7)) >> 3;
    cmd.byte_length = used_after[12:0];
  end

  // running bit offset
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_offset <= '0;
    end else if (cmd_push) begin
      bit_offset <= bit_offset_next;
    end
  end

endmodule

@@ hw/rtl/bfp_store.sv @@
// byte store organized as 8-byte rows with byte write enables
module bfp_store #(
  parameter int ROWS   = 512,
  parameter int ROW_AW = 9
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ROW_AW-1:0] waddr,
  input  logic [7:0]        wbe,
  input  logic [63:0]       wdata,
  input  logic              re,
  input  logic [ROW_AW-1:0] raddr,
  output logic [63:0]       rdata
);

  logic [63:0] mem [ROWS];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      for (int k = 0; k < 8; k++) begin
        if (wbe[k]) begin
          mem[waddr][k*8 +: 8] <= wdata[k*8 +: 8];
        end
      end
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/bfp_back.sv @@
// back end: writes appended bytes, patches the length field and serves reads
module bfp_back #(
  parameter int BUF_BYTES = 4096
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_empty,
  input  bfp_pkg::cmd_t cmd,
  output logic          cmd_pop,
  input  logic          res_full,
  output logic          res_push,
  output bfp_pkg::res_t res,
  input  logic          length_enable,
  input  logic [11:0]   length_field_byte
);

  localparam int ROWS   = (BUF_BYTES + 7) / 8;
  localparam int ROW_AW = $clog2(ROWS);

  bfp_pkg::back_state_t state;
  bfp_pkg::back_state_t state_next;

  // memory port
  logic              we;
  logic [ROW_AW-1:0] waddr;
  logic [7:0]        wbe;
  logic [63:0]       wdata;
  logic              re;
  logic [ROW_AW-1:0] raddr;
  logic [63:0]       rd_row;

  // placement of the head append
  logic [2:0]        p;
  logic [2:0]        b;
  logic [7:0]        sh;
  logic [7:0]        span;
  logic [7:0]        lastj;
  logic [7:0]        tj;
  logic [71:0]       win;
  logic [7:0]        wb [9];
  logic [7:0]        pair_b [16];
  logic [15:0]       pair_be;
  logic [7:0]        tail_new;
  logic [ROW_AW-1:0] row0;
  logic              need_row1;

  // length patch of the head append
  logic [31:0]       fb;
  logic [31:0]       off_a;
  logic [31:0]       len_w;
  logic [31:0]       f_lo;
  logic              need_patch;

  // held across the extra cycles of a transaction
  logic [7:0]        tail;
  logic [63:0]       row1_data;
  logic [7:0]        row1_be;
  logic [ROW_AW-1:0] row1_addr;
  logic              do_patch;
  logic [15:0]       pat_len;
  logic [ROW_AW-1:0] pat_row_hi;
  logic [ROW_AW-1:0] pat_row_lo;
  logic [2:0]        pat_lane_hi;
  logic [2:0]        pat_lane_lo;
  logic              pat_split;
  bfp_pkg::res_t     res_hold;
  logic [2:0]        rd_lane;
  logic              dispatch;

  bfp_store #(
    .ROWS   (ROWS),
    .ROW_AW (ROW_AW)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wbe   (wbe),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rd_row)
  );

  // line the appended bits up behind the partial byte over a pair of rows
  always_comb begin
    int j;
    p     = cmd.off_before[2:0];
    b     = cmd.off_before[5:3];
    span  = {5'b0, p} + {1'b0, cmd.count};
    sh    = 8'd72 - span;
    lastj = (span - 8'd1) >> 3;
    tj    = span >> 3;
    win   = {tail, 64'b0} | ({8'b0, cmd.field} << sh);
    for (int i = 0; i < 9; i++) begin
      wb[i] = win[71 - 8*i -: 8];
    end
    for (int k = 0; k < 16; k++) begin
      j          = k - int'(b);
      pair_b[k]  = 8'h00;
      pair_be[k] = 1'b0;
      if (j >= 0 && j <= 8) begin
        pair_b[k]  = wb[j];
        pair_be[k] = (j <= int'(lastj));
      end
    end
    tail_new  = (tj <= 8'd8) ? wb[tj[3:0]] : 8'h00;
    row0      = ROW_AW'(cmd.off_before >> 6);
    need_row1 = |pair_be[15:8];
  end

  // length field value and rows
  always_comb begin
    fb         = {17'b0, length_field_byte, 3'b000};
    off_a      = 32'(cmd.off_after);
    need_patch = length_enable && (off_a >= fb + 32'd16);
    len_w      = (off_a - fb - 32'd16 + 32'd7) >> 3;
    f_lo       = {20'b0, length_field_byte} + 32'd1;
  end

  assign dispatch = (state == bfp_pkg::B_DISPATCH) && !cmd_empty && !res_full;
  assign raddr    = ROW_AW'(cmd.read_index >> 3);

  // sequencer: next state, memory port and queue handshakes
  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    res_push   = 1'b0;
    res        = res_hold;
    we         = 1'b0;
    waddr      = row0;
    wbe        = '0;
    wdata      = '0;
    re         = 1'b0;

    unique case (state)
      bfp_pkg::B_DISPATCH: begin
        res.read_data   = 8'h00;
        res.byte_length = cmd.byte_length;
        res.status      = cmd.status;
        if (dispatch) begin
          cmd_pop = 1'b1;
          unique case (cmd.kind)
            bfp_pkg::CMD_APPEND: begin
              we  = 1'b1;
              wbe = pair_be[7:0];
              for (int k = 0; k < 8; k++) begin
                wdata[k*8 +: 8] = pair_b[k];
              end
              if (need_row1) begin
                state_next = bfp_pkg::B_WR1;
              end else if (need_patch) begin
                state_next = bfp_pkg::B_PATCH;
              end else begin
                res_push = 1'b1;
              end
            end
            bfp_pkg::CMD_READ: begin
              re         = 1'b1;
              state_next = bfp_pkg::B_READ;
            end
            default: begin
              res_push = 1'b1;
            end
          endcase
        end
      end
      bfp_pkg::B_WR1: begin
        we    = 1'b1;
        waddr = row1_addr;
        wbe   = row1_be;
        wdata = row1_data;
        if (do_patch) begin
          state_next = bfp_pkg::B_PATCH;
        end else begin
          res_push   = 1'b1;
          state_next = bfp_pkg::B_DISPATCH;
        end
      end
      bfp_pkg::B_PATCH: begin
        we    = 1'b1;
        waddr = pat_row_hi;
        wbe   = 8'b1 << pat_lane_hi;
        if (!pat_split) begin
          wbe = wbe | (8'b1 << pat_lane_lo);
        end
        for (int k = 0; k < 8; k++) begin
          wdata[k*8 +: 8] = (3'(k) == pat_lane_hi) ? pat_len[15:8] : pat_len[7:0];
        end
        if (pat_split) begin
          state_next = bfp_pkg::B_PATCH2;
        end else begin
          res_push   = 1'b1;
          state_next = bfp_pkg::B_DISPATCH;
        end
      end
      bfp_pkg::B_PATCH2: begin
        we         = 1'b1;
        waddr      = pat_row_lo;
        wbe        = 8'b1 << pat_lane_lo;
        wdata      = {8{pat_len[7:0]}};
        res_push   = 1'b1;
        state_next = bfp_pkg::B_DISPATCH;
      end
      bfp_pkg::B_READ: begin
        res.read_data = rd_row[rd_lane*8 +: 8];
        res_push      = 1'b1;
        state_next    = bfp_pkg::B_DISPATCH;
      end
      default: begin
        state_next = bfp_pkg::B_DISPATCH;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bfp_pkg::B_DISPATCH;
    end else begin
      state <= state_next;
    end
  end

  // partial byte behind the bit offset
  always_ff @(posedge clk) begin
    if (rst) begin
      tail <= 8'h00;
    end else if (dispatch && cmd.kind == bfp_pkg::CMD_APPEND) begin
      tail <= tail_new;
    end else if (dispatch && cmd.kind == bfp_pkg::CMD_CLEAR) begin
      tail <= 8'h00;
    end
  end

  // capture what the later cycles of a transaction need
  always_ff @(posedge clk) begin
    if (dispatch) begin
      res_hold.read_data   <= 8'h00;
      res_hold.byte_length <= cmd.byte_length;
      res_hold.status      <= cmd.status;
      rd_lane              <= cmd.read_index[2:0];
      for (int k = 0; k < 8; k++) begin
        row1_data[k*8 +: 8] <= pair_b[k+8];
      end
      row1_be     <= pair_be[15:8];
      row1_addr   <= row0 + 1'b1;
      do_patch    <= need_patch;
      pat_len     <= len_w[15:0];
      pat_row_hi  <= ROW_AW'(length_field_byte >> 3);
      pat_row_lo  <= ROW_AW'(f_lo >> 3);
      pat_lane_hi <= length_field_byte[2:0];
      pat_lane_lo <= f_lo[2:0];
      pat_split   <= (length_field_byte[2:0] == 3'd7);
    end
  end

endmodule

@@ hw/rtl/bit_field_packer_with_length.sv @@
// top level of the bit field packer with length field patch
//
//  channel   direction  handshake             payload
//  request   in         push / full           req_type value bit_count start_bit read_index
//  result    out        pop / empty           read_data byte_length status
//  config    in         cfg_write             cfg_index cfg_data
//
// The front takes one request a cycle, while not full, into a two-entry
// command queue. The back writes an append's first 8-byte row in B_DISPATCH,
// the next row in B_WR1 when it crosses into it, then the length field in
// B_PATCH (and B_PATCH2 when the field straddles a row); a read waits in
// B_READ for the registered memory port; clears and rejects end in B_DISPATCH.
// Reset is synchronous; the byte store is not cleared, reads only reach bytes
// written since the last clear. A two-entry result queue lets pop stall alone.
module bit_field_packer_with_length #(
  parameter int BUF_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  req_type,
  input  logic [63:0] value,
  input  logic [6:0]  bit_count,
  input  logic [5:0]  start_bit,
  input  logic [11:0] read_index,
  input  logic        pop,
  output logic        empty,
  output logic [7:0]  read_data,
  output logic [12:0] byte_length,
  output logic [1:0]  status,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  localparam int CMD_W = $bits(bfp_pkg::cmd_t);
  localparam int RES_W = $bits(bfp_pkg::res_t);

  logic              length_enable;
  logic [11:0]       length_field_byte;
  logic              cmd_push;
  logic              cmd_pop;
  logic              cmd_empty;
  bfp_pkg::cmd_t     cmd_in;
  logic [CMD_W-1:0]  cmd_q;
  bfp_pkg::cmd_t     cmd_head;
  logic              res_push;
  logic              res_full;
  bfp_pkg::res_t     res_in;
  logic [RES_W-1:0]  res_q;
  bfp_pkg::res_t     res_head;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      length_enable     <= 1'b0;
      length_field_byte <= 12'd4;
    end else if (cfg_write) begin
      case (cfg_index)
        bfp_pkg::CFG_LENGTH_ENABLE:     length_enable     <= cfg_data[0];
        bfp_pkg::CFG_LENGTH_FIELD_BYTE: length_field_byte <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  bfp_front #(
    .BUF_BYTES (BUF_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .cmd_full   (full),
    .req_type   (req_type),
    .value      (value),
    .bit_count  (bit_count),
    .start_bit  (start_bit),
    .read_index (read_index),
    .cmd_push   (cmd_push),
    .cmd        (cmd_in)
  );

  bfp_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (bfp_pkg::CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .full  (full),
    .wdata (cmd_in),
    .pop   (cmd_pop),
    .empty (cmd_empty),
    .rdata (cmd_q)
  );

  assign cmd_head = bfp_pkg::cmd_t'(cmd_q);

  bfp_back #(
    .BUF_BYTES (BUF_BYTES)
  ) u_back (
    .clk               (clk),
    .rst               (rst),
    .cmd_empty         (cmd_empty),
    .cmd               (cmd_head),
    .cmd_pop           (cmd_pop),
    .res_full          (res_full),
    .res_push          (res_push),
    .res               (res_in),
    .length_enable     (length_enable),
    .length_field_byte (length_field_byte)
  );

  bfp_fifo #(
    .WIDTH (RES_W),
    .DEPTH (bfp_pkg::RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .full  (res_full),
    .wdata (res_in),
    .pop   (pop),
    .empty (empty),
    .rdata (res_q)
  );

  // result ports
  assign res_head    = bfp_pkg::res_t'(res_q);
  assign read_data   = res_head.read_data;
  assign byte_length = res_head.byte_length;
  assign status      = res_head.status;

endmodule

@@ hw/rtl/bfp_checker.sv @@
// port checker for the bit field packer, bound to the top level
module bfp_checker (
  input logic        clk,
  input logic        rst,
  input logic        full,
  input logic        pop,
  input logic        empty,
  input logic [7:0]  read_data,
  input logic [12:0] byte_length,
  input logic [1:0]  status
);

  // the result queue comes out of reset empty and the command queue not full
  a_reset_empty: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not empty after reset");

  // a failed transaction never carries a data byte
  a_fail_no_data: assert property (@(posedge clk) disable iff (rst)
    !empty && status != bfp_pkg::ST_OK |-> read_data == 8'h00)
    else $error("data byte on a failed transaction");

  // a rejected append left waiting keeps the length it reported
  a_range_len: assert property (@(posedge clk) disable iff (rst)
    !empty && (status == bfp_pkg::ST_ILLEGAL || status == bfp_pkg::ST_OVERFLOW)
    && $past(!empty && !pop) |-> $stable(byte_length))
    else $error("length moved under a stalled rejected transaction");

  // a stalled result holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(read_data) && $stable(byte_length)
    && $stable(status))
    else $error("stalled result changed");

endmodule

bind bit_field_packer_with_length bfp_checker u_bfp_checker (
  .clk         (clk),
  .rst         (rst),
  .full        (full),
  .pop         (pop),
  .empty       (empty),
  .read_data   (read_data),
  .byte_length (byte_length),
  .status      (status)
);
